// ===== design/trfp_pkg.sv =====
package trfp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BEGIN = 3'd1,
        PH_NAME  = 3'd2,
        PH_VALUE = 3'd3,
        PH_CKSUM = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        TAG_IGNORED    = 3'd0,
        TAG_NAME_CHAR  = 3'd1,
        TAG_VALUE_CHAR = 3'd2,
        TAG_RECORD     = 3'd3,
        TAG_FRAME_GOOD = 3'd4,
        TAG_FRAME_BAD  = 3'd5
    } t_tag;

    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    localparam logic [3:0] KEY_LEN = 4'd8;

    // characters of the record name "Checksum"
    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h43;
            3'd1: c = 8'h68;
            3'd2: c = 8'h65;
            3'd3: c = 8'h63;
            3'd4: c = 8'h6B;
            3'd5: c = 8'h73;
            3'd6: c = 8'h75;
            3'd7: c = 8'h6D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== design/text_record_frame_parser.sv =====
// Text record frame parser: takes one received byte per request from a stream of
// CR LF name TAB value records closed by a "Checksum" record, and returns one
// tagged result per byte (ignored, name char, value char, record done, frame good,
// frame bad). A byte is accepted every cycle while o_stall is low; its result is
// registered in the output register, or in the skid register if that one is stalled.
// The parse state updates at acceptance, and a two-entry output stage (output
// register plus skid register) lets a byte be taken while the previous result is
// still stalled, so o_stall only rises after two results are held.
module text_record_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_tag,
    output logic [7:0] o_char_out
);

    trfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [3:0]       r_match_cnt, n_match_cnt;
    logic             r_mismatch, n_mismatch;

    logic             r_out_valid, r_skid_valid;
    trfp_pkg::t_tag   r_out_tag, r_skid_tag;
    logic [7:0]       r_out_char, r_skid_char;

    trfp_pkg::t_tag   res_tag;
    logic [7:0]       res_char;
    logic [7:0]       sum_add;
    logic             accept, out_take, out_free;
    logic             trk_hit;

    assign accept   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || out_take;
    assign sum_add  = r_sum + i_rx_byte;

    always_comb begin
        logic [3:0] cnt;
        logic       mis;
        cnt = r_match_cnt;
        mis = r_mismatch;
        n_phase     = r_phase;
        n_sum       = r_sum;
        res_tag     = trfp_pkg::TAG_IGNORED;
        res_char    = 8'h00;
        trk_hit     = 1'b0;
        case (r_phase)
            trfp_pkg::PH_BEGIN: begin
                n_sum = sum_add;
                if (i_rx_byte != trfp_pkg::BYTE_LF) begin
                    cnt      = 4'd0;
                    mis      = 1'b0;
                    trk_hit  = 1'b1;
                    n_phase  = trfp_pkg::PH_NAME;
                    res_tag  = trfp_pkg::TAG_NAME_CHAR;
                    res_char = i_rx_byte;
                end
            end
            trfp_pkg::PH_NAME: begin
                n_sum = sum_add;
                if (i_rx_byte == trfp_pkg::BYTE_TAB) begin
                    if (!r_mismatch && r_match_cnt == trfp_pkg::KEY_LEN) begin
                        n_phase = trfp_pkg::PH_CKSUM;
                    end else begin
                        n_phase = trfp_pkg::PH_VALUE;
                    end
                end else begin
                    trk_hit  = 1'b1;
                    res_tag  = trfp_pkg::TAG_NAME_CHAR;
                    res_char = i_rx_byte;
                end
            end
            trfp_pkg::PH_VALUE: begin
                n_sum = sum_add;
                if (i_rx_byte == trfp_pkg::BYTE_CR) begin
                    res_tag = trfp_pkg::TAG_RECORD;
                    n_phase = trfp_pkg::PH_BEGIN;
                end else begin
                    res_tag  = trfp_pkg::TAG_VALUE_CHAR;
                    res_char = i_rx_byte;
                end
            end
            trfp_pkg::PH_CKSUM: begin
                res_tag = (sum_add == 8'h00) ? trfp_pkg::TAG_FRAME_GOOD
                                             : trfp_pkg::TAG_FRAME_BAD;
                n_sum   = 8'h00;
                n_phase = trfp_pkg::PH_IDLE;
            end
            default: begin
                if (i_rx_byte == trfp_pkg::BYTE_CR) begin
                    n_sum   = sum_add;
                    n_phase = trfp_pkg::PH_BEGIN;
                end else begin
                    n_phase = trfp_pkg::PH_IDLE;
                end
            end
        endcase
        // name match tracker
        if (trk_hit) begin
            if (!mis && cnt < trfp_pkg::KEY_LEN
                && trfp_pkg::key_char(cnt[2:0]) == i_rx_byte) begin
                cnt = cnt + 4'd1;
            end else begin
                mis = 1'b1;
            end
        end
        n_match_cnt = cnt;
        n_mismatch  = mis;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= trfp_pkg::PH_IDLE;
            r_sum       <= 8'h00;
            r_match_cnt <= 4'd0;
            r_mismatch  <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_sum       <= n_sum;
            r_match_cnt <= n_match_cnt;
            r_mismatch  <= n_mismatch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || accept;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_tag  <= r_skid_tag;
                r_out_char <= r_skid_char;
            end else if (accept) begin
                r_out_tag  <= res_tag;
                r_out_char <= res_char;
            end
        end else if (accept) begin
            r_skid_tag  <= res_tag;
            r_skid_char <= res_char;
        end
    end

    assign o_stall    = r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_tag      = r_out_tag;
    assign o_char_out = r_out_char;

endmodule
